@@ rtl/core/lph_pkg.sv @@
// Shared types, codes and hash helpers for the linear probing hash table.
// No dependencies; every other file depends on this package.
package lph_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int SLOT_W    = 10;
	localparam int STAT_W    = 3;
	localparam int KIND_W    = 2;

	localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LKP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REM = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOTF  = 3'd1;
	localparam logic [STAT_W-1:0] ST_DUP   = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
	localparam logic [STAT_W-1:0] ST_ZERO  = 3'd4;

	localparam logic [31:0] HC0 = 32'h7ed55d16;
	localparam logic [31:0] HC1 = 32'hc761c23c;
	localparam logic [31:0] HC2 = 32'h165667b1;
	localparam logic [31:0] HC3 = 32'hd3a2646c;
	localparam logic [31:0] HC4 = 32'hfd7046c5;
	localparam logic [31:0] HC5 = 32'hb55a4f09;

	localparam logic [2:0] HASH_LAST = 3'd5;

	typedef struct packed {
		logic              ld_in;
		logic              ld_scan;
		logic              hash;
		logic              modstep;
		logic              home;
		logic              next;
		logic              wr_probe;
		logic              wr_clr;
		logic              clr_other;
		logic              clr_both;
		logic              i_rst;
		logic              i_inc;
		logic              flip;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              reb;
		logic              res_ld;
		logic [STAT_W-1:0] res_status;
		logic              res_val;
		logic              res_slot;
		logic              out_ld;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              val_zero;
		logic              hash_last;
		logic              mod_last;
		logic              pd_empty;
		logic              pd_match;
		logic              n_last;
		logic              sd_empty;
		logic              i_last;
		logic              full;
	} sts_t;

	function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [2:0] step);
		logic [31:0] r;
		unique case (step)
			3'd0:    r = (h + HC0) + (h << 12);
			3'd1:    r = (h ^ HC1) ^ (h >> 19);
			3'd2:    r = (h + HC2) + (h << 5);
			3'd3:    r = (h + HC3) ^ (h << 9);
			3'd4:    r = (h + HC4) + (h << 3);
			3'd5:    r = (h ^ HC5) ^ (h >> 16);
			default: r = h;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/lph_ifs.sv @@
// Request and response channel interfaces for the hash table.
// Depends on lph_pkg for field widths.
interface lph_req_if;
	logic                      valid;
	logic                      ready;
	logic [lph_pkg::KIND_W-1:0] kind;
	logic [lph_pkg::KEY_W-1:0]  key;
	logic [lph_pkg::VAL_W-1:0]  value;
	modport source (output valid, kind, key, value, input ready);
	modport sink (input valid, kind, key, value, output ready);
endinterface

interface lph_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [lph_pkg::STAT_W-1:0] status;
	logic [lph_pkg::VAL_W-1:0]  found_value;
	logic [lph_pkg::SLOT_W-1:0] slot;
	modport source (output valid, status, found_value, slot, input ready);
	modport sink (input valid, status, found_value, slot, output ready);
endinterface

@@ rtl/core/lph_dp.sv @@
// Datapath: two slot banks, hash and reciprocal modulo unit, probe and scan pointers.
// Depends on lph_pkg; driven by lph_ctrl through cmd_t.
module lph_dp #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lph_pkg::KIND_W-1:0]  kind,
	input  logic [lph_pkg::KEY_W-1:0]   key,
	input  logic [lph_pkg::VAL_W-1:0]   value,
	input  lph_pkg::cmd_t               cmd,
	output lph_pkg::sts_t               sts,
	output logic [lph_pkg::STAT_W-1:0]  status,
	output logic [lph_pkg::VAL_W-1:0]   found_value,
	output logic [lph_pkg::SLOT_W-1:0]  slot
);
	import lph_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = KEY_W + VAL_W;

	localparam logic [64:0] RECIP_W = (65'd1 << (32 + AW)) / 65'(SLOTS);
	localparam logic [32:0] RECIP   = RECIP_W[32:0];

	logic [EW-1:0] mem0 [SLOTS];
	logic [EW-1:0] mem1 [SLOTS];
	logic [EW-1:0] rd0, rd1;

	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [31:0]       h_q;
	logic [2:0]        hstep_q;
	logic [1:0]        mc_q;
	logic [47:0]       pl_q;
	logic [48:0]       ph_q;
	logic [31:0]       q_q;
	logic [32:0]       rm_q;
	logic [AW-1:0]     r_q;
	logic [AW-1:0]     p_q;
	logic [AW-1:0]     n_q;
	logic [AW-1:0]     i_q;
	logic [CW-1:0]     cnt_q;
	logic              cur_q;

	logic [STAT_W-1:0] res_status_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [SLOT_W-1:0] out_slot_q;

	logic          pb;
	logic [EW-1:0] pd, sd;
	logic [AW-1:0] a0, a1, p_nxt;
	logic          we0, we1;
	logic [EW-1:0] wd0, wd1;
	logic [64:0]   psum;
	logic [32:0]   qd;
	logic [CW+3:0] cnt10;

	assign pb    = cur_q ^ cmd.reb;
	assign pd    = pb ? rd1 : rd0;
	assign sd    = cur_q ? rd1 : rd0;
	assign p_nxt = (p_q == AW'(SLOTS - 1)) ? '0 : p_q + 1'b1;
	assign psum  = {ph_q, 16'b0} + {17'b0, pl_q};
	assign qd    = {1'b0, h_q} - 33'({1'b0, q_q} * 33'(SLOTS));
	assign cnt10 = (CW+4)'({cnt_q, 3'b000}) + (CW+4)'({cnt_q, 1'b0});

	always_comb begin
		a0  = (pb == 1'b0) ? p_q : i_q;
		a1  = (pb == 1'b1) ? p_q : i_q;
		we0 = 1'b0;
		we1 = 1'b0;
		wd0 = '0;
		wd1 = '0;
		if (cmd.clr_both) begin
			a0  = i_q;
			a1  = i_q;
			we0 = 1'b1;
			we1 = 1'b1;
		end else if (cmd.clr_other) begin
			if (cur_q) begin
				a0  = i_q;
				we0 = 1'b1;
			end else begin
				a1  = i_q;
				we1 = 1'b1;
			end
		end else if (cmd.wr_probe || cmd.wr_clr) begin
			if (pb) begin
				we1 = 1'b1;
				wd1 = cmd.wr_probe ? {key_q, val_q} : '0;
			end else begin
				we0 = 1'b1;
				wd0 = cmd.wr_probe ? {key_q, val_q} : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we0)
			mem0[a0] <= wd0;
		rd0 <= mem0[a0];
	end

	always_ff @(posedge clk) begin
		if (we1)
			mem1[a1] <= wd1;
		rd1 <= mem1[a1];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			kind_q  <= kind;
			key_q   <= key;
			val_q   <= value;
			h_q     <= key;
			hstep_q <= '0;
			mc_q    <= '0;
			r_q     <= '0;
		end else if (cmd.ld_scan) begin
			key_q   <= sd[EW-1:VAL_W];
			val_q   <= sd[VAL_W-1:0];
			h_q     <= sd[EW-1:VAL_W];
			hstep_q <= '0;
			mc_q    <= '0;
			r_q     <= '0;
		end else if (cmd.hash) begin
			h_q     <= hash_step(h_q, hstep_q);
			hstep_q <= hstep_q + 1'b1;
		end else if (cmd.modstep) begin
			case (mc_q)
				2'd0: begin
					pl_q <= {16'b0, h_q} * {32'b0, RECIP[15:0]};
					ph_q <= {17'b0, h_q} * {32'b0, RECIP[32:16]};
				end
				2'd1: begin
					q_q <= 32'(psum >> (32 + AW));
				end
				2'd2: begin
					rm_q <= qd;
				end
				default: begin
					r_q <= (rm_q >= 33'(SLOTS)) ? AW'(rm_q - 33'(SLOTS)) : AW'(rm_q);
				end
			endcase
			mc_q <= mc_q + 1'b1;
		end
		if (cmd.home) begin
			p_q <= r_q;
			n_q <= '0;
		end else if (cmd.next) begin
			p_q <= p_nxt;
			n_q <= n_q + 1'b1;
		end
		if (cmd.res_ld) begin
			res_status_q <= cmd.res_status;
			res_val_q    <= cmd.res_val ? pd[VAL_W-1:0] : '0;
			res_slot_q   <= cmd.res_slot ? SLOT_W'(p_q) : '0;
		end
		if (cmd.out_ld) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
			out_slot_q   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			cnt_q <= '0;
			cur_q <= 1'b0;
		end else begin
			if (cmd.i_rst)
				i_q <= '0;
			else if (cmd.i_inc)
				i_q <= i_q + 1'b1;
			if (cmd.cnt_inc)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec && cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.flip)
				cur_q <= ~cur_q;
		end
	end

	assign sts.kind      = kind_q;
	assign sts.val_zero  = (val_q == '0);
	assign sts.hash_last = (hstep_q == HASH_LAST);
	assign sts.mod_last  = (mc_q == 2'd3);
	assign sts.pd_empty  = (pd[VAL_W-1:0] == '0);
	assign sts.pd_match  = (pd[EW-1:VAL_W] == key_q);
	assign sts.n_last    = (n_q == AW'(SLOTS - 1));
	assign sts.sd_empty  = (sd[VAL_W-1:0] == '0);
	assign sts.i_last    = (i_q == AW'(SLOTS - 1));
	assign sts.full      = (cnt10 > (CW+4)'(SLOTS * 7));

	assign status      = out_status_q;
	assign found_value = out_val_q;
	assign slot        = out_slot_q;

endmodule

@@ rtl/core/lph_ctrl.sv @@
// Controller state machine: sequences hashing, probing, rebuild and clearing.
// Depends on lph_pkg; drives lph_dp through cmd_t.
module lph_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lph_pkg::sts_t sts,
	output lph_pkg::cmd_t cmd
);
	import lph_pkg::*;

	localparam logic [3:0] S_RST  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC  = 4'd2;
	localparam logic [3:0] S_HASH = 4'd3;
	localparam logic [3:0] S_MOD  = 4'd4;
	localparam logic [3:0] S_HOME = 4'd5;
	localparam logic [3:0] S_WAIT = 4'd6;
	localparam logic [3:0] S_CHK  = 4'd7;
	localparam logic [3:0] S_CLR  = 4'd8;
	localparam logic [3:0] S_SCAN = 4'd9;
	localparam logic [3:0] S_SCHK = 4'd10;
	localparam logic [3:0] S_SNXT = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0] state_q, state_d;
	logic       reb_q, reb_d;
	logic       ov_q, ov_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd     = '0;
		cmd.reb = reb_q;
		state_d = state_q;
		reb_d   = reb_q;
		ov_d    = ov_q && !out_ready;
		unique case (state_q)
			S_RST: begin
				cmd.clr_both = 1'b1;
				cmd.i_inc    = 1'b1;
				if (sts.i_last) begin
					cmd.i_rst = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.kind == KIND_BAD) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = ST_NOTF;
					state_d        = S_DONE;
				end else if (sts.kind == KIND_INS && sts.val_zero) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = ST_ZERO;
					state_d        = S_DONE;
				end else begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				if (sts.hash_last)
					state_d = S_MOD;
			end
			S_MOD: begin
				cmd.modstep = 1'b1;
				if (sts.mod_last)
					state_d = S_HOME;
			end
			S_HOME: begin
				cmd.home = 1'b1;
				state_d  = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (reb_q) begin
					if (sts.pd_empty) begin
						cmd.wr_probe = 1'b1;
						state_d      = S_SNXT;
					end else if (sts.n_last) begin
						state_d = S_SNXT;
					end else begin
						cmd.next = 1'b1;
						state_d  = S_WAIT;
					end
				end else if (sts.pd_empty || (sts.n_last && !sts.pd_match)) begin
					cmd.res_ld = 1'b1;
					state_d    = S_DONE;
					if (sts.kind == KIND_INS) begin
						if (sts.full || !sts.pd_empty) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.res_status = ST_OK;
							cmd.wr_probe   = 1'b1;
							cmd.cnt_inc    = 1'b1;
						end
					end else begin
						cmd.res_status = ST_NOTF;
					end
				end else if (sts.pd_match) begin
					cmd.res_ld = 1'b1;
					state_d    = S_DONE;
					if (sts.kind == KIND_INS) begin
						cmd.res_status = ST_DUP;
					end else if (sts.kind == KIND_LKP) begin
						cmd.res_status = ST_OK;
						cmd.res_val    = 1'b1;
						cmd.res_slot   = 1'b1;
					end else begin
						cmd.res_status = ST_OK;
						cmd.res_val    = 1'b1;
						cmd.wr_clr     = 1'b1;
						cmd.cnt_dec    = 1'b1;
						cmd.i_rst      = 1'b1;
						state_d        = S_CLR;
					end
				end else begin
					cmd.next = 1'b1;
					state_d  = S_WAIT;
				end
			end
			S_CLR: begin
				cmd.clr_other = 1'b1;
				cmd.i_inc     = 1'b1;
				if (sts.i_last) begin
					cmd.i_rst = 1'b1;
					reb_d     = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (!sts.sd_empty) begin
					cmd.ld_scan = 1'b1;
					state_d     = S_HASH;
				end else begin
					state_d = S_SNXT;
				end
			end
			S_SNXT: begin
				if (sts.i_last) begin
					cmd.flip  = 1'b1;
					cmd.i_rst = 1'b1;
					reb_d     = 1'b0;
					state_d   = S_DONE;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.out_ld = 1'b1;
					ov_d       = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST;
			reb_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			reb_q   <= reb_d;
			ov_q    <= ov_d;
		end
	end

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// Linear probing hash table with 32-bit keys and values, one operation at a time.
// Insert and lookup hash the key, reduce it modulo SLOTS, then probe slots in turn
// from the home slot. A zero-value insert or an unused kind is answered without hashing.
// A remove that hits clears the spare bank, then scans every slot and re-places each
// live entry in the spare bank; the banks then swap roles.
// After reset both banks are cleared with req.ready low.
module linear_probe_hash_table #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	lph_req_if.sink   req,
	lph_rsp_if.source rsp
);
	import lph_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lph_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (req.kind),
		.key         (req.key),
		.value       (req.value),
		.cmd         (cmd),
		.sts         (sts),
		.status      (rsp.status),
		.found_value (rsp.found_value),
		.slot        (rsp.slot)
	);

endmodule

@@ verif/tb_linear_probe_hash_table.sv @@
// Self-checking testbench for linear_probe_hash_table: random and directed map operations,
// each response compared against a local table model.
// Depends on lph_pkg, lph_ifs and the linear_probe_hash_table RTL.
module tb_linear_probe_hash_table;
	import lph_pkg::*;

	localparam int TBL_SLOTS  = SLOTS_DEF;
	localparam int IDLE_LIMIT = 500000;
	localparam int POOL_N     = 48;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} op_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  found_value;
		logic [SLOT_W-1:0] slot;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lph_req_if req ();
	lph_rsp_if rsp ();

	linear_probe_hash_table DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [KEY_W-1:0] tbl_keys [TBL_SLOTS];
	logic [VAL_W-1:0] tbl_vals [TBL_SLOTS];
	int unsigned tbl_count;

	op_t     pending_ops[$];
	result_t expected_results[$];
	logic [KEY_W-1:0] key_pool[POOL_N];

	int errors;
	int sent;
	int idle_cycles;
	int status_seen[8];
	bit drain_done;
	bit quiet_tail;

	function automatic logic [31:0] mix32(input logic [31:0] k);
		logic [31:0] h;
		h = k;
		h = (h + 32'h7ed55d16) + (h << 12);
		h = (h ^ 32'hc761c23c) ^ (h >> 19);
		h = (h + 32'h165667b1) + (h << 5);
		h = (h + 32'hd3a2646c) ^ (h << 9);
		h = (h + 32'hfd7046c5) + (h << 3);
		h = (h ^ 32'hb55a4f09) ^ (h >> 16);
		return h;
	endfunction

	function automatic bit find_key(input logic [KEY_W-1:0] k, output int where);
		int s;
		s = int'(mix32(k) % TBL_SLOTS);
		where = 0;
		for (int n = 0; n < TBL_SLOTS; n++) begin
			if (tbl_vals[s] == '0)
				return 1'b0;
			if (tbl_keys[s] == k) begin
				where = s;
				return 1'b1;
			end
			s = (s + 1 >= TBL_SLOTS) ? 0 : s + 1;
		end
		return 1'b0;
	endfunction

	function automatic result_t apply_op(input op_t op);
		result_t r;
		int pos;
		int s;
		bit placed;
		logic [KEY_W-1:0] old_keys [TBL_SLOTS];
		logic [VAL_W-1:0] old_vals [TBL_SLOTS];
		r = '{status: ST_NOTF, found_value: '0, slot: '0};
		case (op.kind)
			KIND_INS: begin
				if (op.value == '0) begin
					r.status = ST_ZERO;
				end else if (find_key(op.key, pos)) begin
					r.status = ST_DUP;
				end else if (tbl_count * 10 > TBL_SLOTS * 7) begin
					r.status = ST_FULL;
				end else begin
					placed = 1'b0;
					s = int'(mix32(op.key) % TBL_SLOTS);
					for (int n = 0; n < TBL_SLOTS && !placed; n++) begin
						if (tbl_vals[s] == '0) begin
							tbl_keys[s] = op.key;
							tbl_vals[s] = op.value;
							placed = 1'b1;
						end
						s = (s + 1 >= TBL_SLOTS) ? 0 : s + 1;
					end
					if (placed) begin
						tbl_count++;
						r.status = ST_OK;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			KIND_LKP: begin
				if (find_key(op.key, pos)) begin
					r.status = ST_OK;
					r.found_value = tbl_vals[pos];
					r.slot = SLOT_W'(pos);
				end
			end
			KIND_REM: begin
				if (find_key(op.key, pos)) begin
					r.status = ST_OK;
					r.found_value = tbl_vals[pos];
					tbl_vals[pos] = '0;
					tbl_keys[pos] = '0;
					old_keys = tbl_keys;
					old_vals = tbl_vals;
					foreach (tbl_vals[i]) begin
						tbl_vals[i] = '0;
						tbl_keys[i] = '0;
					end
					for (int i = 0; i < TBL_SLOTS; i++) begin
						if (old_vals[i] != '0) begin
							placed = 1'b0;
							s = int'(mix32(old_keys[i]) % TBL_SLOTS);
							for (int n = 0; n < TBL_SLOTS && !placed; n++) begin
								if (tbl_vals[s] == '0) begin
									tbl_keys[s] = old_keys[i];
									tbl_vals[s] = old_vals[i];
									placed = 1'b1;
								end
								s = (s + 1 >= TBL_SLOTS) ? 0 : s + 1;
							end
						end
					end
					if (tbl_count > 0)
						tbl_count--;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic op_t mk_op(input logic [KIND_W-1:0] k, input logic [31:0] ky,
			input logic [31:0] v);
		op_t o;
		o.kind = k;
		o.key = ky;
		o.value = v;
		return o;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 32'hffffffff;
			1: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom() | 32'h1;
		endcase
	endfunction

	// driver
	int drv_hold;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.kind <= '0;
			req.key <= '0;
			req.value <= '0;
			drv_hold = 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_op(pending_ops[0]));
				void'(pending_ops.pop_front());
				sent++;
			end
			if (req.valid && !req.ready) begin
				// hold until transfer
			end else if (sent == 900 && !drain_done) begin
				req.valid <= 1'b0;
				if (expected_results.size() == 0)
					drain_done = 1'b1;
			end else if (drv_hold > 0) begin
				drv_hold--;
				req.valid <= 1'b0;
			end else if (pending_ops.size() == 0) begin
				req.valid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				drv_hold = $urandom_range(1, 6) - 1;
				req.valid <= 1'b0;
			end else begin
				req.valid <= 1'b1;
				req.kind <= pending_ops[0].kind;
				req.key <= pending_ops[0].key;
				req.value <= pending_ops[0].value;
			end
		end
	end

	// monitor
	int mon_hold;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			mon_hold = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected response status=%0d", rsp.status);
					errors++;
				end else begin
					if (rsp.status !== expected_results[0].status) begin
						$error("status expected %0d actual %0d",
							expected_results[0].status, rsp.status);
						errors++;
					end
					if (rsp.found_value !== expected_results[0].found_value) begin
						$error("found_value expected %h actual %h",
							expected_results[0].found_value, rsp.found_value);
						errors++;
					end
					if (rsp.slot !== expected_results[0].slot) begin
						$error("slot expected %0d actual %0d",
							expected_results[0].slot, rsp.slot);
						errors++;
					end
					status_seen[expected_results[0].status]++;
					void'(expected_results.pop_front());
				end
			end
			if (mon_hold > 0) begin
				mon_hold--;
				rsp.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				mon_hold = $urandom_range(1, 6) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int pick;
		logic [31:0] ky;
		req.valid = 1'b0;
		req.kind = '0;
		req.key = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		errors = 0;
		sent = 0;
		idle_cycles = 0;
		drain_done = 1'b0;
		quiet_tail = 1'b0;
		tbl_count = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		foreach (tbl_vals[i]) begin
			tbl_vals[i] = '0;
			tbl_keys[i] = '0;
		end
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hffffffff;

		// directed: extremes, every kind, not-found, duplicate and zero-value refusals
		pending_ops.push_back(mk_op(KIND_LKP, 32'h0, 32'h0));
		pending_ops.push_back(mk_op(KIND_REM, 32'h0, 32'h0));
		pending_ops.push_back(mk_op(KIND_INS, 32'h0, 32'hffffffff));
		pending_ops.push_back(mk_op(KIND_INS, 32'hffffffff, 32'h1));
		pending_ops.push_back(mk_op(KIND_INS, 32'h12345678, 32'h0));
		pending_ops.push_back(mk_op(KIND_INS, 32'h0, 32'h5));
		pending_ops.push_back(mk_op(KIND_LKP, 32'h0, 32'h0));
		pending_ops.push_back(mk_op(KIND_LKP, 32'hffffffff, 32'hffffffff));
		pending_ops.push_back(mk_op(KIND_BAD, 32'hffffffff, 32'hffffffff));
		pending_ops.push_back(mk_op(KIND_BAD, 32'h0, 32'h0));
		for (int i = 0; i < 6; i++)
			pending_ops.push_back(mk_op(KIND_INS, 32'h100 + i, 32'h80000000 >> i));
		pending_ops.push_back(mk_op(KIND_REM, 32'h0, 32'h0));
		pending_ops.push_back(mk_op(KIND_LKP, 32'h0, 32'h0));
		pending_ops.push_back(mk_op(KIND_LKP, 32'h103, 32'h0));
		pending_ops.push_back(mk_op(KIND_REM, 32'h103, 32'h0));
		pending_ops.push_back(mk_op(KIND_REM, 32'h103, 32'h0));
		pending_ops.push_back(mk_op(KIND_LKP, 32'h105, 32'h0));

		// random traffic on a small key pool keeps the table light
		for (int i = 0; i < 1000; i++) begin
			pick = $urandom_range(0, 99);
			ky = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, POOL_N-1)];
			if (pick < 40)
				pending_ops.push_back(mk_op(KIND_INS, ky, rand_value()));
			else if (pick < 75)
				pending_ops.push_back(mk_op(KIND_LKP, ky, $urandom()));
			else if (pick < 88)
				pending_ops.push_back(mk_op(KIND_REM, ky, $urandom()));
			else if (pick < 94)
				pending_ops.push_back(mk_op(KIND_INS, ky, 32'h0));
			else
				pending_ops.push_back(mk_op(KIND_BAD, ky, $urandom()));
		end

		// fill past the load limit, then free one entry and refill
		for (int i = 0; i < 740; i++) begin
			pending_ops.push_back(mk_op(KIND_INS, 32'h10000000 + i, rand_value()));
			if (i % 37 == 0)
				pending_ops.push_back(mk_op(KIND_LKP, 32'h10000000 + $urandom_range(0, i), 0));
		end
		pending_ops.push_back(mk_op(KIND_REM, 32'h10000000, 32'h0));
		pending_ops.push_back(mk_op(KIND_INS, 32'h20000000, 32'hdeadbeef));
		pending_ops.push_back(mk_op(KIND_INS, 32'h20000001, 32'h1));
		pending_ops.push_back(mk_op(KIND_LKP, 32'h20000000, 32'h0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() > 60)
			@(posedge clk);
		quiet_tail = 1'b1;
		while (pending_ops.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("Covered %0d operations: ok %0d, not found %0d, duplicate %0d,", sent,
			status_seen[ST_OK], status_seen[ST_NOTF], status_seen[ST_DUP]);
		$display("full %0d, zero value %0d; checked %0d mismatches.", status_seen[ST_FULL],
			status_seen[ST_ZERO], errors);
		if (errors == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
